/* design/assert_macros.svh */
// Assertion helpers for the design files; scpc_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NORST(lbl, prop, msg)
`endif
`endif

/* design/scpc_pkg.sv */
`timescale 1ns / 1ps
package scpc_pkg;
  localparam int SETS_DEF = 1024;
  localparam int WAYS_DEF = 16;
  localparam int LPP_DEF  = 64;

  localparam int TIME_W = 48;
  localparam int CNT_W  = 16;
  localparam int MASK_W = 64;
  localparam int AGE_W  = 6;
  localparam int SETF_W = 16;

  localparam logic [2:0] OP_PROBE = 3'd0;
  localparam logic [2:0] OP_FILL  = 3'd1;
  localparam logic [2:0] OP_RD    = 3'd2;
  localparam logic [2:0] OP_WR    = 3'd3;
  localparam logic [2:0] OP_EVICT = 3'd4;
  localparam logic [2:0] OP_COUNT = 3'd5;
  localparam logic [2:0] OP_PROMO = 3'd6;

  localparam logic [1:0] HIT_READY = 2'd0;
  localparam logic [1:0] HIT_WAIT  = 2'd1;
  localparam logic [1:0] HIT_MISS  = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLEAN = 2'd1;
  localparam logic [1:0] EV_DIRTY = 2'd2;

  localparam logic [1:0] CFG_MAX_THR = 2'd0;
  localparam logic [1:0] CFG_EPOCH   = 2'd1;
  localparam logic [1:0] CFG_LOW     = 2'd2;
  localparam logic [1:0] CFG_HIGH    = 2'd3;

  localparam logic [15:0] MAX_THR_RST = 16'd8;
  localparam logic [31:0] EPOCH_RST   = 32'd1048576;
  localparam logic [8:0]  LOW_RST     = 9'd51;
  localparam logic [8:0]  HIGH_RST    = 9'd205;

  typedef struct packed {
    logic [2:0]        op;
    logic [31:0]       page_index;
    logic [5:0]        line_offset;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] ready_at;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        hit_status;
    logic [TIME_W-1:0] wait_time;
    logic [1:0]        evict_kind;
    logic [31:0]       victim_index;
    logic [6:0]        accessed_lines;
    logic [6:0]        dirty_lines;
    logic [CNT_W-1:0]  page_count;
    logic              promote;
    logic              error;
  } out_item_t;

  // Decoded operation as it waits for the back end.
  typedef struct packed {
    logic [2:0]        op;
    logic [SETF_W-1:0] set;
    logic [31:0]       tag;
    logic [5:0]        line;
    logic              line_ok;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] rdy;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic              ready;
    logic [31:0]       tag;
    logic [TIME_W-1:0] rtime;
    logic [CNT_W-1:0]  count;
    logic [MASK_W-1:0] acc;
    logic [MASK_W-1:0] wr;
    logic [AGE_W-1:0]  age;
  } entry_t;

  function automatic logic [6:0] popcnt64(input logic [MASK_W-1:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) n = n + 7'(v[i]);
    return n;
  endfunction
endpackage

/* design/scpc_stream_if.sv */
`timescale 1ns / 1ps
interface scpc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/scpc_front.sv */
`timescale 1ns / 1ps
module scpc_front import scpc_pkg::*; #(
  parameter int SETS = SETS_DEF,
  parameter int LPP  = LPP_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  scpc_stream_if.sink   in_ch,
  input  logic          clr_busy,
  output job_t          q_job,
  output logic          q_vld,
  input  logic          q_pop
);
  job_t       q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  job_t       job_new;
  logic       push;

  // Split the page into set and tag and flag lines outside the page.
  always_comb begin
    job_new.op      = in_ch.data.op;
    job_new.set     = SETF_W'(in_ch.data.page_index % SETS);
    job_new.tag     = in_ch.data.page_index / SETS;
    job_new.line    = in_ch.data.line_offset;
    job_new.line_ok = {26'd0, in_ch.data.line_offset} < 32'(LPP);
    job_new.now     = in_ch.data.now_time;
    job_new.rdy     = in_ch.data.ready_at;
  end

  assign in_ch.ready = (cnt_r != 2'd2) && !clr_busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_vld       = cnt_r != 2'd0;
  assign q_job       = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= job_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

/* design/scpc_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scpc_back import scpc_pkg::*; #(
  parameter int SETS = SETS_DEF,
  parameter int WAYS = WAYS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  job_t          q_job,
  input  logic          q_vld,
  output logic          q_pop,
  output logic          clr_busy,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  scpc_stream_if.source out_ch
);
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int OCC_W = $clog2(WAYS + 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LK   = 2'd2;
  localparam logic [1:0] ST_EX   = 2'd3;

  entry_t [WAYS-1:0] row_mem [SETS];
  entry_t [WAYS-1:0] rd_row_r;
  entry_t [WAYS-1:0] row_n;

  logic [1:0]       state_r, state_nxt;
  logic [SET_W-1:0] clr_r;
  job_t             job_r;

  logic [15:0] max_thr_r;
  logic [31:0] epoch_cfg_r;
  logic [8:0]  low_r, high_r;
  logic [15:0] thr_r, thr_nxt;
  logic [31:0] psum_r, psum_nxt, epoch_r, epoch_nxt, res_r, res_nxt;

  logic [WAYS-1:0]  hitv, freev, vicv;
  logic [OCC_W-1:0] occ;
  logic [WAY_W-1:0] hw, fw, vw;
  logic             hit_r, ff_r, full_r;
  logic [WAY_W-1:0] hw_r, fw_r, vw_r;
  logic [31:0]      ep1, ep1_r;
  logic [40:0]      prodlo_r, prodhi_r;

  logic             mem_we, mem_re, commit;
  logic [SET_W-1:0] mem_wa;
  entry_t [WAYS-1:0] mem_wd;

  out_item_t        res, out_data_r;
  logic             out_vld_r;

  entry_t           e, v;
  logic             drop_en;
  logic [WAY_W-1:0] drop_w;
  logic [CNT_W-1:0] cnt;
  logic             prom;
  logic [32:0]      psum_add;
  logic [40:0]      lhs;
  logic [63:0]      vic_idx;

  // Tag compare, free way and LRU victim over the row just read.
  // Ages of valid entries form 0..occupancy-1, so the victim of a full set has
  // the oldest possible age.
  always_comb begin
    occ = '0;
    hw  = '0;
    fw  = '0;
    vw  = '0;
    for (int w = 0; w < WAYS; w++) begin
      hitv[w]  = rd_row_r[w].valid && (rd_row_r[w].tag == job_r.tag);
      freev[w] = !rd_row_r[w].valid;
      vicv[w]  = rd_row_r[w].valid && (rd_row_r[w].age == AGE_W'(WAYS - 1));
      occ      = occ + OCC_W'(rd_row_r[w].valid);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hitv[w])  hw = WAY_W'(w);
      if (freev[w]) fw = WAY_W'(w);
      if (vicv[w])  vw = WAY_W'(w);
    end
    ep1 = (epoch_r == '1) ? epoch_r : epoch_r + 32'd1;
  end

  // Update of the row and of the promotion statistics.
  always_comb begin
    row_n     = rd_row_r;
    res       = '0;
    thr_nxt   = thr_r;
    psum_nxt  = psum_r;
    epoch_nxt = epoch_r;
    res_nxt   = res_r;
    drop_en   = 1'b0;
    drop_w    = hw_r;
    e         = rd_row_r[hw_r];
    v         = rd_row_r[vw_r];
    cnt       = (e.count == '1) ? e.count : e.count + CNT_W'(1);
    prom      = cnt >= thr_r;
    psum_add  = 33'(psum_r) + 33'(cnt);
    lhs       = '0;
    vic_idx   = 64'(v.tag) * 64'(SETS) + 64'(job_r.set);
    case (job_r.op) inside
      OP_PROBE: begin
        if (!hit_r) begin
          res.hit_status = HIT_MISS;
        end else if (!e.ready) begin
          if (job_r.now >= e.rtime) begin
            row_n[hw_r].ready = 1'b1;
          end else begin
            res.hit_status = HIT_WAIT;
            res.wait_time  = e.rtime - job_r.now;
          end
        end
      end
      OP_FILL: begin
        if (hit_r || full_r || !ff_r) begin
          res.error = 1'b1;
        end else begin
          for (int w = 0; w < WAYS; w++)
            if (rd_row_r[w].valid) row_n[w].age = rd_row_r[w].age + AGE_W'(1);
          row_n[fw_r]       = '0;
          row_n[fw_r].valid = 1'b1;
          row_n[fw_r].tag   = job_r.tag;
          row_n[fw_r].rtime = job_r.rdy;
        end
      end
      OP_RD, OP_WR: begin
        if (!hit_r) begin
          res.error = 1'b1;
        end else begin
          for (int w = 0; w < WAYS; w++)
            if (rd_row_r[w].valid && rd_row_r[w].age < e.age)
              row_n[w].age = rd_row_r[w].age + AGE_W'(1);
          row_n[hw_r].age = '0;
          if (job_r.op == OP_WR) row_n[hw_r].dirty = 1'b1;
          if (job_r.line_ok) begin
            row_n[hw_r].acc[job_r.line] = 1'b1;
            if (job_r.op == OP_WR) row_n[hw_r].wr[job_r.line] = 1'b1;
          end
        end
      end
      OP_EVICT: begin
        if (full_r) begin
          res.evict_kind     = v.dirty ? EV_DIRTY : EV_CLEAN;
          res.victim_index   = vic_idx[31:0];
          res.accessed_lines = popcnt64(v.acc);
          res.dirty_lines    = popcnt64(v.wr);
          res.page_count     = v.count;
          drop_en            = 1'b1;
          drop_w             = vw_r;
        end
      end
      OP_COUNT: begin
        if (!hit_r) begin
          res.error = 1'b1;
        end else begin
          res_nxt   = (res_r == '1) ? res_r : res_r + 32'd1;
          epoch_nxt = ep1_r;
          if (prom) psum_nxt = psum_add[32] ? '1 : psum_add[31:0];
          lhs = {1'b0, psum_nxt, 8'd0};
          if (lhs <= prodlo_r) begin
            if (thr_r < max_thr_r) thr_nxt = thr_r + 16'd1;
          end else if (lhs >= prodhi_r) begin
            if (thr_r > 16'd1 && prom) thr_nxt = thr_r - 16'd1;
          end
          if (ep1_r >= epoch_cfg_r) begin
            epoch_nxt = res_nxt;
            psum_nxt  = '0;
            thr_nxt   = max_thr_r;
          end
          row_n[hw_r].count = cnt;
          res.page_count    = cnt;
          res.promote       = prom;
        end
      end
      OP_PROMO: begin
        if (!hit_r) begin
          res.error = 1'b1;
        end else begin
          res.page_count = e.count;
          drop_en        = 1'b1;
        end
      end
      default: ;
    endcase
    if (drop_en) begin
      row_n[drop_w].valid = 1'b0;
      row_n[drop_w].dirty = 1'b0;
      row_n[drop_w].ready = 1'b0;
      for (int w = 0; w < WAYS; w++)
        if (rd_row_r[w].valid && rd_row_r[w].age > rd_row_r[drop_w].age)
          row_n[w].age = rd_row_r[w].age - AGE_W'(1);
      res_nxt = (res_r >= 32'(rd_row_r[drop_w].count)) ?
                res_r - 32'(rd_row_r[drop_w].count) : '0;
    end
  end

  assign commit   = (state_r == ST_EX) && (!out_vld_r || out_ch.ready);
  assign q_pop    = (state_r == ST_IDLE) && q_vld;
  assign clr_busy = state_r == ST_CLR;
  assign mem_re   = q_pop;
  assign mem_we   = (state_r == ST_CLR) || commit;
  assign mem_wa   = (state_r == ST_CLR) ? clr_r : SET_W'(job_r.set);
  assign mem_wd   = (state_r == ST_CLR) ? '0 : row_n;

  always_ff @(posedge clk) begin
    if (mem_we) row_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_row_r <= row_mem[SET_W'(q_job.set)];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_r == SET_W'(SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (q_vld) state_nxt = ST_LK;
      ST_LK:   state_nxt = ST_EX;
      ST_EX:   if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    if (state_r == ST_LK) begin
      hit_r    <= |hitv;
      ff_r     <= |freev;
      full_r   <= occ >= OCC_W'(WAYS);
      hw_r     <= hw;
      fw_r     <= fw;
      vw_r     <= vw;
      ep1_r    <= ep1;
      prodlo_r <= 41'(low_r) * 41'(ep1);
      prodhi_r <= 41'(high_r) * 41'(ep1);
    end
    if (commit) out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_vld_r   <= 1'b0;
      max_thr_r   <= MAX_THR_RST;
      epoch_cfg_r <= EPOCH_RST;
      low_r       <= LOW_RST;
      high_r      <= HIGH_RST;
      thr_r       <= MAX_THR_RST;
      psum_r      <= '0;
      epoch_r     <= '0;
      res_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + SET_W'(1);
      if (commit) begin
        out_vld_r <= 1'b1;
        thr_r     <= thr_nxt;
        psum_r    <= psum_nxt;
        epoch_r   <= epoch_nxt;
        res_r     <= res_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_THR: max_thr_r   <= cfg_wdata[15:0];
          CFG_EPOCH:   epoch_cfg_r <= cfg_wdata;
          CFG_LOW:     low_r       <= cfg_wdata[8:0];
          CFG_HIGH:    high_r      <= cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  `ASSERT_CLK(a_clr_no_pop, (state_r == ST_CLR) |-> !q_pop, "pop during clearing pass")
  `ASSERT_CLK(a_hit_unique, (state_r == ST_LK) |-> $onehot0(hitv), "page resident twice")
  `ASSERT_CLK(a_commit_out, commit |=> out_vld_r, "committed result not shown")
endmodule

/* design/set_assoc_lru_page_cache_promotion_top.sv */
`timescale 1ns / 1ps
// Set-associative LRU page cache with an adaptive promotion threshold. Each
// operation goes through the back end as a synchronous read of the set's row,
// tag compare and LRU/victim selection, and an update that writes the row back
// and loads the result register once the output can take it. A two-entry
// queue in front takes items while the back end works. After reset the block
// sweeps the tag memory one row per cycle and accepts no item until that pass
// ends; configuration writes are taken throughout.
module set_assoc_lru_page_cache_promotion_top import scpc_pkg::*; #(
  parameter int SETS           = SETS_DEF,
  parameter int WAYS           = WAYS_DEF,
  parameter int LINES_PER_PAGE = LPP_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  scpc_stream_if.sink   in_ch,
  scpc_stream_if.source out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);
  job_t q_job;
  logic q_vld, q_pop, clr_busy;

  scpc_front #(.SETS(SETS), .LPP(LINES_PER_PAGE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .clr_busy (clr_busy),
    .q_job    (q_job),
    .q_vld    (q_vld),
    .q_pop    (q_pop)
  );

  scpc_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (q_job),
    .q_vld     (q_vld),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );
endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
  import scpc_pkg::*;

  localparam int NSETS  = SETS_DEF;
  localparam int NWAYS  = WAYS_DEF;
  localparam int NLINES = LPP_DEF;

  typedef struct {
    logic        valid;
    logic        dirty;
    logic        ready;
    logic [21:0] tag;
    logic [47:0] rtime;
    logic [15:0] cnt;
    logic [63:0] acc;
    logic [63:0] wr;
    int          age;
  } page_slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MAX_THR;
  logic [31:0] cfg_wdata = '0;

  scpc_stream_if #(.T(in_item_t))  in_if();
  scpc_stream_if #(.T(out_item_t)) out_if();

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
  end

  set_assoc_lru_page_cache_promotion_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow of the cache and the promotion controller
  page_slot_t  slots [NSETS*NWAYS];
  int          set_fill [NSETS];
  logic [15:0] thr_ceiling = MAX_THR_RST;
  logic [31:0] epoch_limit = EPOCH_RST;
  logic [8:0]  low_q8 = LOW_RST;
  logic [8:0]  high_q8 = HIGH_RST;
  logic [15:0] cur_thr = MAX_THR_RST;
  logic [31:0] promoted_sum = '0;
  logic [31:0] epoch_cnt = '0;
  logic [31:0] resident_cnt = '0;

  in_item_t  pending_ops [$];
  out_item_t expected_res [$];
  int  errors = 0;
  int  n_results = 0;
  int  n_promotes = 0;
  int  n_evicts = 0;
  int  n_waits = 0;
  bit  burst_mode = 1'b0;
  logic [47:0] tbase = '0;

  function automatic void queue_op(in_item_t it);
    pending_ops.insert(pending_ops.size(), it);
  endfunction

  function automatic void drop_page(int base, int way);
    int old;
    old = slots[base+way].age;
    slots[base+way].valid = 1'b0;
    slots[base+way].dirty = 1'b0;
    slots[base+way].ready = 1'b0;
    for (int w = 0; w < NWAYS; w++)
      if (slots[base+w].valid && slots[base+w].age > old) slots[base+w].age--;
    if (set_fill[base/NWAYS] > 0) set_fill[base/NWAYS]--;
    resident_cnt = (resident_cnt >= 32'(slots[base+way].cnt)) ?
                   resident_cnt - 32'(slots[base+way].cnt) : '0;
  endfunction

  function automatic out_item_t cache_predict(in_item_t it);
    out_item_t   r;
    int          st, base, way, vw, old;
    logic [21:0] tg;
    logic        prom;
    logic [63:0] lhs, ep;
    logic [32:0] sum;
    r    = '0;
    st   = int'(it.page_index[9:0]);
    tg   = it.page_index[31:10];
    base = st * NWAYS;
    way  = -1;
    for (int w = 0; w < NWAYS; w++)
      if (way < 0 && slots[base+w].valid && slots[base+w].tag == tg) way = w;
    case (it.op)
      OP_PROBE: begin
        if (way < 0) r.hit_status = HIT_MISS;
        else if (!slots[base+way].ready) begin
          if (it.now_time >= slots[base+way].rtime) slots[base+way].ready = 1'b1;
          else begin
            r.hit_status = HIT_WAIT;
            r.wait_time  = slots[base+way].rtime - it.now_time;
          end
        end
      end
      OP_FILL: begin
        if (way >= 0 || set_fill[st] >= NWAYS) r.error = 1'b1;
        else begin
          vw = -1;
          for (int w = 0; w < NWAYS; w++)
            if (vw < 0 && !slots[base+w].valid) vw = w;
          for (int w = 0; w < NWAYS; w++)
            if (slots[base+w].valid) slots[base+w].age++;
          slots[base+vw] = '{1'b1, 1'b0, 1'b0, tg, it.ready_at, 16'd0, 64'd0, 64'd0, 0};
          set_fill[st]++;
        end
      end
      OP_RD, OP_WR: begin
        if (way < 0) r.error = 1'b1;
        else begin
          old = slots[base+way].age;
          for (int w = 0; w < NWAYS; w++)
            if (slots[base+w].valid && slots[base+w].age < old) slots[base+w].age++;
          slots[base+way].age = 0;
          if (it.op == OP_WR) slots[base+way].dirty = 1'b1;
          if (int'(it.line_offset) < NLINES) begin
            slots[base+way].acc[it.line_offset] = 1'b1;
            if (it.op == OP_WR) slots[base+way].wr[it.line_offset] = 1'b1;
          end
        end
      end
      OP_EVICT: begin
        if (set_fill[st] >= NWAYS) begin
          vw = -1;
          for (int w = 0; w < NWAYS; w++)
            if (slots[base+w].valid && (vw < 0 || slots[base+w].age > slots[base+vw].age))
              vw = w;
          if (vw >= 0) begin
            r.evict_kind     = slots[base+vw].dirty ? EV_DIRTY : EV_CLEAN;
            r.victim_index   = {slots[base+vw].tag, it.page_index[9:0]};
            r.accessed_lines = 7'($countones(slots[base+vw].acc));
            r.dirty_lines    = 7'($countones(slots[base+vw].wr));
            r.page_count     = slots[base+vw].cnt;
            drop_page(base, vw);
          end
        end
      end
      OP_COUNT: begin
        if (way < 0) r.error = 1'b1;
        else begin
          if (resident_cnt != '1) resident_cnt++;
          if (epoch_cnt != '1) epoch_cnt++;
          if (slots[base+way].cnt != '1) slots[base+way].cnt++;
          prom = slots[base+way].cnt >= cur_thr;
          if (prom) begin
            sum = 33'(promoted_sum) + 33'(slots[base+way].cnt);
            promoted_sum = sum[32] ? '1 : sum[31:0];
          end
          lhs = 64'(promoted_sum) * 64'd256;
          ep  = 64'(epoch_cnt);
          if (lhs <= 64'(low_q8) * ep) begin
            if (cur_thr < thr_ceiling) cur_thr++;
          end else if (lhs >= 64'(high_q8) * ep) begin
            if (cur_thr > 16'd1 && prom) cur_thr--;
          end
          if (epoch_cnt >= epoch_limit) begin
            epoch_cnt    = resident_cnt;
            promoted_sum = '0;
            cur_thr      = thr_ceiling;
          end
          r.page_count = slots[base+way].cnt;
          r.promote    = prom;
        end
      end
      OP_PROMO: begin
        if (way < 0) r.error = 1'b1;
        else begin
          r.page_count = slots[base+way].cnt;
          drop_page(base, way);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: hold the beat until taken, then advance after a random gap
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_res.insert(expected_res.size(), cache_predict(in_if.data));
        send_gap = pick_gap();
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_if.data  <= pending_ops.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: one long hold-off part way through lets the block back up
  int hold = 0;
  always @(posedge clk) begin
    out_item_t e, a;
    int r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        a = out_if.data;
        n_results++;
        if (expected_res.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none actual %0h", $time, a);
        end else begin
          e = expected_res.pop_front();
          check_field("hit_status", 64'(e.hit_status), 64'(a.hit_status));
          check_field("wait_time", 64'(e.wait_time), 64'(a.wait_time));
          check_field("evict_kind", 64'(e.evict_kind), 64'(a.evict_kind));
          check_field("victim_index", 64'(e.victim_index), 64'(a.victim_index));
          check_field("accessed_lines", 64'(e.accessed_lines), 64'(a.accessed_lines));
          check_field("dirty_lines", 64'(e.dirty_lines), 64'(a.dirty_lines));
          check_field("page_count", 64'(e.page_count), 64'(a.page_count));
          check_field("promote", 64'(e.promote), 64'(a.promote));
          check_field("error", 64'(e.error), 64'(a.error));
          if (e.promote) n_promotes++;
          if (e.evict_kind != EV_NONE) n_evicts++;
          if (e.hit_status == HIT_WAIT) n_waits++;
        end
        if (n_results == 200) hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (burst_mode) begin
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(8, 40);
        end
      end
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic in_item_t make_op(logic [2:0] op, logic [31:0] page, logic [5:0] line,
                                       logic [47:0] now_t, logic [47:0] rdy_t);
    in_item_t it;
    it.op = op;
    it.page_index = page;
    it.line_offset = line;
    it.now_time = now_t;
    it.ready_at = rdy_t;
    return it;
  endfunction

  function automatic in_item_t random_op();
    logic [2:0]  op;
    logic [31:0] page;
    logic [47:0] now_t, rdy_t;
    int r;
    r = $urandom_range(0, 99);
    op = (r < 22) ? OP_FILL : (r < 37) ? OP_PROBE : (r < 50) ? OP_RD : (r < 63) ? OP_WR :
         (r < 75) ? OP_EVICT : (r < 92) ? OP_COUNT : (r < 98) ? OP_PROMO : 3'd7;
    // mostly a few hot sets with a tag pool larger than the ways
    if ($urandom_range(0, 9) < 8)
      page = {22'($urandom_range(0, 21)) ^ (($urandom_range(0, 20) == 0) ? 22'h3FFFF0 : 22'h0),
              10'($urandom_range(0, 2) == 2 ? 1023 : $urandom_range(0, 1))};
    else
      page = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      now_t = rand48();
      rdy_t = rand48();
    end else begin
      now_t = tbase + 48'($urandom_range(0, 2000));
      rdy_t = tbase + 48'($urandom_range(0, 2000));
    end
    return make_op(op, page, 6'($urandom), now_t, rdy_t);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MAX_THR: thr_ceiling = val[15:0];
      CFG_EPOCH:   epoch_limit = val;
      CFG_LOW:     low_q8      = val[8:0];
      default:     high_q8     = val[8:0];
    endcase
  endtask

  // Recheck after the settle time: a beat may be loaded as the queue empties
  task automatic drain();
    do begin
      wait (pending_ops.size() == 0 && !in_if.valid && expected_res.size() == 0);
      repeat (12) @(posedge clk);
    end while (pending_ops.size() != 0 || in_if.valid || expected_res.size() != 0);
  endtask

  task automatic set_regs(logic [31:0] thr, logic [31:0] ep, logic [31:0] lo, logic [31:0] hi);
    drain();
    write_reg(CFG_MAX_THR, thr);
    write_reg(CFG_EPOCH, ep);
    write_reg(CFG_LOW, lo);
    write_reg(CFG_HIGH, hi);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    tbase = ($urandom_range(0, 1) == 0) ? 48'd0 : rand48() - 48'd5000;
    repeat (n) queue_op(random_op());
  endtask

  initial begin
    for (int i = 0; i < NSETS*NWAYS; i++) slots[i] = '{default: '0};
    for (int i = 0; i < NSETS; i++) set_fill[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every op, full set, absent page, unused op
    queue_op(make_op(OP_PROBE, 32'd0, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_FILL, 32'd0, 6'd0, 48'd0, '1));
    queue_op(make_op(OP_PROBE, 32'd0, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_PROBE, 32'd0, 6'd0, '1, 48'd0));
    queue_op(make_op(OP_FILL, 32'd0, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_RD, 32'd0, 6'd63, 48'd0, 48'd0));
    queue_op(make_op(OP_WR, 32'd0, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_COUNT, 32'd0, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_EVICT, 32'd0, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_FILL, '1, 6'h2A, 48'd0, 48'd5));
    queue_op(make_op(OP_PROBE, '1, 6'd0, 48'd4, 48'd0));
    for (int t = 1; t < NWAYS; t++)
      queue_op(make_op(OP_FILL, 32'(t * NSETS), 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_FILL, 32'(NWAYS * NSETS), 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_EVICT, 32'd5 * NSETS, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_PROMO, 32'd0, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_PROMO, 32'd0, 6'd0, 48'd0, 48'd0));
    queue_op(make_op(OP_RD, 32'd77, 6'd1, 48'd0, 48'd0));
    queue_op(make_op(OP_COUNT, 32'd77, 6'd1, 48'd0, 48'd0));
    queue_op(make_op(3'd7, 32'd1024, 6'd5, 48'd0, 48'd0));

    random_phase(110);
    set_regs(32'd1, 32'd1, 32'd0, 32'd256);
    random_phase(110);
    set_regs(32'd65535, 32'hFFFF_FFFF, 32'd256, 32'd0);
    burst_mode = 1'b1;
    random_phase(110);
    drain();
    burst_mode = 1'b0;
    set_regs(32'd3, 32'd40, 32'd51, 32'd205);
    random_phase(110);
    // ceiling below the running threshold
    set_regs(32'd2, 32'd1000, 32'd128, 32'd140);
    random_phase(110);

    drain();
    repeat (20) @(posedge clk);
    $display("Checked %0d results: %0d promotions, %0d evictions, %0d waiting probes",
             n_results, n_promotes, n_evicts, n_waits);
    $display("Covered five register settings with stalls, bursts and a long output hold");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout with %0d results outstanding", expected_res.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
